>>> sv/serial_line_edit_buffer_defines.svh
// Assertion macros used by the serial line edit buffer datapath.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SERIAL_LINE_EDIT_BUFFER_DEFINES_SVH
`define SERIAL_LINE_EDIT_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLEB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLEB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sleb_pkg.sv
// Package for the serial line edit buffer: sizes, character codes, result kinds,
// echo plans and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sleb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);
    localparam int RCNT_W     = 6;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_QM  = 8'h3f;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_DELIV = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PLAN_ECHO    = 3'd0,
        PLAN_FULL    = 3'd1,
        PLAN_CR      = 3'd2,
        PLAN_CR_FULL = 3'd3,
        PLAN_ERASE   = 3'd4,
        PLAN_BEL     = 3'd5
    } t_plan;

    typedef struct packed {
        logic       load_in;
        logic       store;
        logic       store_lf;
        logic       erase;
        logic       rd_prev;
        logic       rd_tail;
        logic       out_load;
        t_kind      out_kind;
        t_plan      plan;
        logic [1:0] step;
    } t_cmd;

    typedef struct packed {
        logic is_bs;
        logic is_cr;
        logic empty;
        logic full;
        logic rdata_lf;
        logic count_done;
        logic out_free;
    } t_stat;

    function automatic logic [1:0] plan_last(input t_plan plan);
        logic [1:0] res;
        case (plan)
            PLAN_FULL:    res = 2'd2;
            PLAN_CR:      res = 2'd1;
            PLAN_CR_FULL: res = 2'd1;
            PLAN_ERASE:   res = 2'd2;
            default:      res = 2'd0;
        endcase
        return res;
    endfunction

    function automatic logic plan_is_cr(input t_plan plan);
        return (plan == PLAN_CR) || (plan == PLAN_CR_FULL);
    endfunction

    function automatic logic [7:0] echo_byte(input t_plan plan, input logic [1:0] step,
                                             input logic [7:0] ch);
        logic [7:0] res;
        case (plan)
            PLAN_ECHO:    res = ch;
            PLAN_FULL:    res = (step == 2'd0) ? CH_BS : ((step == 2'd1) ? CH_BEL : CH_QM);
            PLAN_CR:      res = (step == 2'd0) ? CH_CR : CH_LF;
            PLAN_CR_FULL: res = (step == 2'd0) ? CH_BS : CH_QM;
            PLAN_ERASE:   res = (step == 2'd1) ? CH_SP : CH_BS;
            default:      res = CH_BEL;
        endcase
        return res;
    endfunction

endpackage

>>> sv/sleb_ctrl.sv
// Controller of the serial line edit buffer: one-hot state machine that
// sequences echo, delivery and done items. Depends on sleb_pkg.
`timescale 1ns / 1ps

module sleb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_operation,
    output logic            o_in_stall,
    input  sleb_pkg::t_stat i_stat,
    output sleb_pkg::t_cmd  o_cmd
);
    import sleb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RX_DEC = 7'b0000010,
        S_BS_CHK = 7'b0000100,
        S_ECHO   = 7'b0001000,
        S_RD_CHK = 7'b0010000,
        S_RD_OUT = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    t_plan      r_plan, n_plan;
    logic [1:0] r_step, n_step;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_plan  = r_plan;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.plan     = r_plan;
        o_cmd.step     = r_step;
        o_cmd.out_kind = KIND_ECHO;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_in_operation ? S_RD_CHK : S_RX_DEC;
                end
            end
            S_RX_DEC: begin
                n_step  = 2'd0;
                n_state = S_ECHO;
                if (i_stat.is_bs) begin
                    if (i_stat.empty) begin
                        n_plan = PLAN_BEL;
                    end else begin
                        o_cmd.rd_prev = 1'b1;
                        n_state = S_BS_CHK;
                    end
                end else if (i_stat.is_cr) begin
                    if (i_stat.full) begin
                        n_plan = PLAN_CR_FULL;
                    end else begin
                        o_cmd.store    = 1'b1;
                        o_cmd.store_lf = 1'b1;
                        n_plan = PLAN_CR;
                    end
                end else begin
                    if (i_stat.full) begin
                        n_plan = PLAN_FULL;
                    end else begin
                        o_cmd.store = 1'b1;
                        n_plan = PLAN_ECHO;
                    end
                end
            end
            S_BS_CHK: begin
                n_state = S_ECHO;
                if (i_stat.rdata_lf) begin
                    n_plan = PLAN_BEL;
                end else begin
                    o_cmd.erase = 1'b1;
                    n_plan = PLAN_ERASE;
                end
            end
            S_ECHO: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_step == plan_last(r_plan)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end
            S_RD_CHK: begin
                if (i_stat.count_done || i_stat.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_tail = 1'b1;
                    n_state = S_RD_OUT;
                end
            end
            S_RD_OUT: begin
                o_cmd.out_kind = KIND_DELIV;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = i_stat.rdata_lf ? S_DONE : S_RD_CHK;
                end
            end
            S_DONE: begin
                o_cmd.out_kind = KIND_DONE;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plan  <= PLAN_BEL;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_plan  <= n_plan;
            r_step  <= n_step;
        end
    end

endmodule

>>> sv/sleb_dp.sv
// Datapath of the serial line edit buffer: ring memory, head, tail and fill
// registers, input latch and the output register. Depends on sleb_pkg and
// serial_line_edit_buffer_defines.svh.
`timescale 1ns / 1ps
`include "serial_line_edit_buffer_defines.svh"

module sleb_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_in_rx_byte,
    input  logic [sleb_pkg::RCNT_W-1:0] i_in_read_count,
    input  sleb_pkg::t_cmd              i_cmd,
    output sleb_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_out_result_kind,
    output logic [7:0]                  o_out_byte,
    output logic [sleb_pkg::RCNT_W-1:0] o_out_delivered_count,
    output logic                        o_out_line_complete,
    output logic                        o_out_last
);
    import sleb_pkg::*;

    logic [7:0]        r_mem [RING_DEPTH];
    logic [7:0]        r_rdata;
    logic [IDX_W-1:0]  r_head, r_tail, n_head, n_tail;
    logic [IDX_W-1:0]  head_prev, head_inc, tail_inc, rd_addr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_ch;
    logic [RCNT_W-1:0] r_want, r_got;
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [7:0]        r_out_byte;
    logic [RCNT_W-1:0] r_out_count;
    logic              r_out_line, r_out_last;
    logic              out_free, echo_last;
    logic [7:0]        wdata;

    assign head_prev = (r_head == '0) ? IDX_W'(RING_DEPTH - 1) : r_head - 1'b1;
    assign head_inc  = (r_head == IDX_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc  = (r_tail == IDX_W'(RING_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign rd_addr   = i_cmd.rd_prev ? head_prev : r_tail;
    assign wdata     = i_cmd.store_lf ? CH_LF : r_ch;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign echo_last = (i_cmd.step == plan_last(i_cmd.plan));

    assign o_stat.is_bs      = (r_ch == CH_BS);
    assign o_stat.is_cr      = (r_ch == CH_CR);
    assign o_stat.empty      = (r_fill == '0);
    assign o_stat.full       = (r_fill == FILL_W'(RING_DEPTH));
    assign o_stat.rdata_lf   = (r_rdata == CH_LF);
    assign o_stat.count_done = (r_got == r_want);
    assign o_stat.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_head] <= wdata;
        end
        if (i_cmd.rd_prev || i_cmd.rd_tail) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_cmd.store) begin
            n_head = head_inc;
            n_fill = r_fill + 1'b1;
        end else if (i_cmd.erase) begin
            n_head = head_prev;
            n_fill = r_fill - 1'b1;
        end else if (i_cmd.rd_tail) begin
            n_tail = tail_inc;
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch   <= i_in_rx_byte;
            r_want <= i_in_read_count;
            r_got  <= '0;
        end else if (i_cmd.rd_tail) begin
            r_got <= r_got + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            case (i_cmd.out_kind)
                KIND_ECHO: begin
                    r_out_byte  <= echo_byte(i_cmd.plan, i_cmd.step, r_ch);
                    r_out_count <= '0;
                    r_out_line  <= echo_last && plan_is_cr(i_cmd.plan);
                    r_out_last  <= echo_last;
                end
                KIND_DELIV: begin
                    r_out_byte  <= r_rdata;
                    r_out_count <= '0;
                    r_out_line  <= 1'b0;
                    r_out_last  <= 1'b0;
                end
                default: begin
                    r_out_byte  <= 8'h00;
                    r_out_count <= r_got;
                    r_out_line  <= 1'b0;
                    r_out_last  <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_result_kind     = r_out_kind;
    assign o_out_byte            = r_out_byte;
    assign o_out_delivered_count = r_out_count;
    assign o_out_line_complete   = r_out_line;
    assign o_out_last            = r_out_last;

    `SLEB_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= FILL_W'(RING_DEPTH), "fill above depth")
    `SLEB_ASSERT_IMP(a_no_store_full, i_cmd.store, r_fill != FILL_W'(RING_DEPTH), "store when full")
    `SLEB_ASSERT_IMP(a_no_take_empty, i_cmd.erase || i_cmd.rd_tail, r_fill != '0, "take when empty")
    `SLEB_ASSERT_NXT(a_load_shows, i_cmd.out_load && out_free, r_out_valid, "loaded item not shown")

endmodule

>>> sv/serial_line_edit_buffer.sv
// Top level of the serial line edit buffer: joins the controller and datapath.
// Depends on sleb_pkg, sleb_ctrl and sleb_dp.
`timescale 1ns / 1ps

// Line-editing receive front end for a serial terminal with a 256-byte ring
// buffer. One item is worked at a time; the input stalls until its last result
// has been loaded into the output register. Because the ring memory has one
// port with a registered read, a receive item passes a decode state, a check
// state when a backspace looks up the newest byte, and an echo state per echo
// byte, and a read item passes a check and an output state per delivered byte,
// skips the check after a newline, then ends in a done state; output states
// wait while the output is stalled. The memory needs no clearing after reset.
module serial_line_edit_buffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_in_operation,
    input  logic [7:0]                  i_in_rx_byte,
    input  logic [sleb_pkg::RCNT_W-1:0] i_in_read_count,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_out_result_kind,
    output logic [7:0]                  o_out_byte,
    output logic [sleb_pkg::RCNT_W-1:0] o_out_delivered_count,
    output logic                        o_out_line_complete,
    output logic                        o_out_last
);
    import sleb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sleb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_operation (i_in_operation),
        .o_in_stall     (o_in_stall),
        .i_stat         (stat),
        .o_cmd          (cmd)
    );

    sleb_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_rx_byte          (i_in_rx_byte),
        .i_in_read_count       (i_in_read_count),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_out_result_kind     (o_out_result_kind),
        .o_out_byte            (o_out_byte),
        .o_out_delivered_count (o_out_delivered_count),
        .o_out_line_complete   (o_out_line_complete),
        .o_out_last            (o_out_last)
    );

endmodule
